[design/bmrp_pkg.sv]
package bmrp_pkg;

	localparam logic [4:0] FLAG_LEN  = 5'd1;
	localparam logic [4:0] WIDTH_LEN = 5'd5;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_BITS
	} state_t;

	typedef enum logic [3:0] {
		PH_SF, PH_SNB, PH_SX, PH_SY,
		PH_RF, PH_RNB, PH_KA, PH_KB,
		PH_TNB, PH_TX, PH_TY
	} phase_t;

	typedef enum logic [1:0] {
		EXP_FLAG,
		EXP_WIDTH,
		EXP_VALUE_NEW,
		EXP_VALUE
	} exp_sel_t;

	typedef struct packed {
		logic       load_byte;
		logic       shift;
		logic       expect_en;
		exp_sel_t   exp_sel;
		logic       load_width;
		logic       set_flag0;
		logic       set_flag1;
		logic       store_en;
		logic [2:0] store_sel;
		logic       emit_ok;
		logic       emit_trunc;
		logic       ty_zero;
		logic       restart;
	} cmd_t;

	typedef struct packed {
		logic field_done;
		logic last_bit;
		logic last_flag;
		logic bit0;
		logic new_w_zero;
		logic out_free;
	} sts_t;

endpackage

[design/bmrp_ctrl.sv]
module bmrp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  bmrp_pkg::sts_t sts,
	output bmrp_pkg::cmd_t cmd
);

	bmrp_pkg::state_t state_q, state_d;
	bmrp_pkg::phase_t phase_q, phase_d, phase_nx;

	logic rec_done;
	logic trunc;
	logic need_emit;
	logic go;

	assign rec_done  = sts.field_done &&
		(phase_q == bmrp_pkg::PH_TY || (phase_q == bmrp_pkg::PH_TNB && sts.new_w_zero));
	assign trunc     = sts.last_bit && sts.last_flag && !rec_done;
	assign need_emit = rec_done || trunc;
	assign go        = !need_emit || sts.out_free;
	assign in_stall  = (state_q != bmrp_pkg::ST_IDLE);

	always_comb begin
		unique case (phase_q)
			bmrp_pkg::PH_SF:  phase_nx = sts.bit0 ? bmrp_pkg::PH_SNB : bmrp_pkg::PH_RF;
			bmrp_pkg::PH_SNB: phase_nx = sts.new_w_zero ? bmrp_pkg::PH_RF : bmrp_pkg::PH_SX;
			bmrp_pkg::PH_SX:  phase_nx = bmrp_pkg::PH_SY;
			bmrp_pkg::PH_SY:  phase_nx = bmrp_pkg::PH_RF;
			bmrp_pkg::PH_RF:  phase_nx = sts.bit0 ? bmrp_pkg::PH_RNB : bmrp_pkg::PH_TNB;
			bmrp_pkg::PH_RNB: phase_nx = sts.new_w_zero ? bmrp_pkg::PH_TNB : bmrp_pkg::PH_KA;
			bmrp_pkg::PH_KA:  phase_nx = bmrp_pkg::PH_KB;
			bmrp_pkg::PH_KB:  phase_nx = bmrp_pkg::PH_TNB;
			bmrp_pkg::PH_TNB: phase_nx = bmrp_pkg::PH_TX;
			bmrp_pkg::PH_TX:  phase_nx = bmrp_pkg::PH_TY;
			default:          phase_nx = bmrp_pkg::PH_SF;
		endcase
	end

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		unique case (state_q)
			bmrp_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = bmrp_pkg::ST_BITS;
				end
			end
			bmrp_pkg::ST_BITS: begin
				if (go) begin
					if (need_emit) begin
						state_d = bmrp_pkg::ST_IDLE;
						phase_d = bmrp_pkg::PH_SF;
					end else begin
						if (sts.field_done) begin
							phase_d = phase_nx;
						end
						if (sts.last_bit) begin
							state_d = bmrp_pkg::ST_IDLE;
						end
					end
				end
			end
			default: state_d = bmrp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.exp_sel = bmrp_pkg::EXP_FLAG;
		unique case (state_q)
			bmrp_pkg::ST_IDLE: begin
				cmd.load_byte = in_valid;
			end
			bmrp_pkg::ST_BITS: begin
				if (go) begin
					cmd.shift = 1'b1;
					if (need_emit) begin
						cmd.emit_ok    = rec_done;
						cmd.emit_trunc = !rec_done;
						cmd.ty_zero    = (phase_q == bmrp_pkg::PH_TNB);
						cmd.restart    = 1'b1;
					end else if (sts.field_done) begin
						cmd.expect_en = 1'b1;
						unique case (phase_nx) inside
							bmrp_pkg::PH_SNB, bmrp_pkg::PH_RNB, bmrp_pkg::PH_TNB:
								cmd.exp_sel = bmrp_pkg::EXP_WIDTH;
							bmrp_pkg::PH_SX, bmrp_pkg::PH_KA, bmrp_pkg::PH_TX:
								cmd.exp_sel = bmrp_pkg::EXP_VALUE_NEW;
							bmrp_pkg::PH_SY, bmrp_pkg::PH_KB, bmrp_pkg::PH_TY:
								cmd.exp_sel = bmrp_pkg::EXP_VALUE;
							default:
								cmd.exp_sel = bmrp_pkg::EXP_FLAG;
						endcase
						unique case (phase_q)
							bmrp_pkg::PH_SF:  cmd.set_flag0 = 1'b1;
							bmrp_pkg::PH_RF:  cmd.set_flag1 = 1'b1;
							bmrp_pkg::PH_SNB, bmrp_pkg::PH_RNB, bmrp_pkg::PH_TNB:
								cmd.load_width = 1'b1;
							bmrp_pkg::PH_SX: begin
								cmd.store_en  = 1'b1;
								cmd.store_sel = 3'd0;
							end
							bmrp_pkg::PH_SY: begin
								cmd.store_en  = 1'b1;
								cmd.store_sel = 3'd1;
							end
							bmrp_pkg::PH_KA: begin
								cmd.store_en  = 1'b1;
								cmd.store_sel = 3'd2;
							end
							bmrp_pkg::PH_KB: begin
								cmd.store_en  = 1'b1;
								cmd.store_sel = 3'd3;
							end
							bmrp_pkg::PH_TX: begin
								cmd.store_en  = 1'b1;
								cmd.store_sel = 3'd4;
							end
							default: cmd.store_en = 1'b0;
						endcase
					end
				end
			end
			default: cmd.load_byte = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmrp_pkg::ST_IDLE;
			phase_q <= bmrp_pkg::PH_SF;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

endmodule

[design/bmrp_dpath.sv]
module bmrp_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         in_byte,
	input  logic               end_of_data,
	input  logic               out_stall,
	input  bmrp_pkg::cmd_t     cmd,
	output bmrp_pkg::sts_t     sts,
	output logic               out_valid,
	output logic               status,
	output logic               has_scale,
	output logic signed [30:0] scale_x,
	output logic signed [30:0] scale_y,
	output logic               has_rotate,
	output logic signed [30:0] skew_a,
	output logic signed [30:0] skew_b,
	output logic signed [30:0] move_x,
	output logic signed [30:0] move_y,
	output logic [4:0]         record_bytes
);

	function automatic logic [30:0] sext31(input logic [30:0] v, input logic [4:0] w);
		logic [30:0] m;
		logic        sb;
		m  = ~(31'h7FFF_FFFF << w);
		sb = (w == 5'd0) ? 1'b0 : v[w - 5'd1];
		return (v & m) | (sb ? ~m : 31'd0);
	endfunction

	logic [7:0]  byte_q;
	logic [2:0]  cnt_q;
	logic        last_q;
	logic [30:0] accum_q;
	logic [4:0]  bits_left_q;
	logic [4:0]  width_q;
	logic [30:0] vals_q [5];
	logic [1:0]  flags_q;
	logic [4:0]  byte_count_q;
	logic        out_valid_q;

	logic [30:0] v;
	logic [30:0] sv;
	logic [4:0]  exp_len;

	assign v  = {accum_q[29:0], byte_q[7]};
	assign sv = sext31(v, width_q);

	always_comb begin
		case (cmd.exp_sel)
			bmrp_pkg::EXP_FLAG:      exp_len = bmrp_pkg::FLAG_LEN;
			bmrp_pkg::EXP_WIDTH:     exp_len = bmrp_pkg::WIDTH_LEN;
			bmrp_pkg::EXP_VALUE_NEW: exp_len = v[4:0];
			default:                 exp_len = width_q;
		endcase
	end

	assign sts.field_done = (bits_left_q == 5'd1);
	assign sts.last_bit   = (cnt_q == 3'd0);
	assign sts.last_flag  = last_q;
	assign sts.bit0       = v[0];
	assign sts.new_w_zero = (v[4:0] == 5'd0);
	assign sts.out_free   = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			byte_q <= in_byte;
			last_q <= end_of_data;
		end else if (cmd.shift) begin
			byte_q <= {byte_q[6:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= 3'd0;
			accum_q      <= 31'd0;
			bits_left_q  <= bmrp_pkg::FLAG_LEN;
			width_q      <= 5'd0;
			flags_q      <= 2'b00;
			byte_count_q <= 5'd0;
			for (int i = 0; i < 5; i++) begin
				vals_q[i] <= 31'd0;
			end
		end else begin
			if (cmd.load_byte) begin
				cnt_q        <= 3'd7;
				byte_count_q <= byte_count_q + 5'd1;
			end else if (cmd.shift) begin
				cnt_q <= cnt_q - 3'd1;
			end
			if (cmd.restart) begin
				accum_q      <= 31'd0;
				bits_left_q  <= bmrp_pkg::FLAG_LEN;
				width_q      <= 5'd0;
				flags_q      <= 2'b00;
				byte_count_q <= 5'd0;
				for (int i = 0; i < 5; i++) begin
					vals_q[i] <= 31'd0;
				end
			end else if (cmd.shift) begin
				if (cmd.expect_en) begin
					accum_q     <= 31'd0;
					bits_left_q <= exp_len;
				end else begin
					accum_q     <= v;
					bits_left_q <= bits_left_q - 5'd1;
				end
				if (cmd.load_width) begin
					width_q <= v[4:0];
				end
				if (cmd.set_flag0) begin
					flags_q[0] <= v[0];
				end
				if (cmd.set_flag1) begin
					flags_q[1] <= v[0];
				end
				if (cmd.store_en) begin
					vals_q[cmd.store_sel] <= sv;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_ok || cmd.emit_trunc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ok) begin
			status       <= 1'b0;
			has_scale    <= flags_q[0];
			scale_x      <= vals_q[0];
			scale_y      <= vals_q[1];
			has_rotate   <= flags_q[1];
			skew_a       <= vals_q[2];
			skew_b       <= vals_q[3];
			move_x       <= vals_q[4];
			move_y       <= cmd.ty_zero ? 31'd0 : sv;
			record_bytes <= byte_count_q;
		end else if (cmd.emit_trunc) begin
			status       <= 1'b1;
			has_scale    <= 1'b0;
			scale_x      <= 31'd0;
			scale_y      <= 31'd0;
			has_rotate   <= 1'b0;
			skew_a       <= 31'd0;
			skew_b       <= 31'd0;
			move_x       <= 31'd0;
			move_y       <= 31'd0;
			record_bytes <= byte_count_q;
		end
	end

endmodule

[design/bitpacked_matrix_record_parser_core.sv]
// Bit-packed matrix record parser.
// Input channel: in_valid / in_stall carry one stream byte (in_byte) per
// transaction, read most significant bit first; end_of_data marks the last
// byte of the buffer. Output channel: out_valid / out_stall carry one result
// per record: flags, sign-extended scale, skew and translate values, the
// record size in bytes, and status (1 when the data ended mid-record).
// Each byte is accepted and then walked bit by bit through the single
// bit-serial field extractor, so the next byte is not taken until the
// current one is through. in_stall stays high while the bits are walked.
// The result is registered at the edge that consumes the closing bit; the
// rest of that byte is dropped and the next byte is taken on the following
// cycle. A truncation result is registered at the edge that consumes the
// last bit of the last byte.
// The output register holds a finished result while the receiver stalls;
// the next byte is still taken and parsed, and the extractor only holds when
// a second result is ready before the first is taken.
// Reset clears the parser to the start of a record with an empty output.
module bitpacked_matrix_record_parser_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         in_byte,
	input  logic               end_of_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               status,
	output logic               has_scale,
	output logic signed [30:0] scale_x,
	output logic signed [30:0] scale_y,
	output logic               has_rotate,
	output logic signed [30:0] skew_a,
	output logic signed [30:0] skew_b,
	output logic signed [30:0] move_x,
	output logic signed [30:0] move_y,
	output logic [4:0]         record_bytes
);

	bmrp_pkg::cmd_t cmd;
	bmrp_pkg::sts_t sts;

	bmrp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bmrp_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_byte      (in_byte),
		.end_of_data  (end_of_data),
		.out_stall    (out_stall),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.status       (status),
		.has_scale    (has_scale),
		.scale_x      (scale_x),
		.scale_y      (scale_y),
		.has_rotate   (has_rotate),
		.skew_a       (skew_a),
		.skew_b       (skew_b),
		.move_x       (move_x),
		.move_y       (move_y),
		.record_bytes (record_bytes)
	);

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

	typedef struct {
		logic        status;
		logic        has_scale;
		logic [30:0] scale_x;
		logic [30:0] scale_y;
		logic        has_rotate;
		logic [30:0] skew_a;
		logic [30:0] skew_b;
		logic [30:0] move_x;
		logic [30:0] move_y;
		logic [4:0]  record_bytes;
	} matrix_result_t;

	class record_scoreboard;
		matrix_result_t    pending_records[$];
		bmrp_pkg::phase_t  phase;
		logic [4:0]        fwidth;
		logic [4:0]        bits_left;
		logic [30:0]       accum;
		logic [30:0]       vals [5];
		logic [1:0]        flags;
		logic [4:0]        nbytes;
		int                errors;
		int                checked;
		int                truncated;

		function new();
			errors = 0;
			checked = 0;
			truncated = 0;
			restart();
		endfunction

		function void restart();
			phase = bmrp_pkg::PH_SF;
			fwidth = '0;
			bits_left = bmrp_pkg::FLAG_LEN;
			accum = '0;
			foreach (vals[i]) vals[i] = '0;
			flags = '0;
			nbytes = '0;
		endfunction

		function void arm(bmrp_pkg::phase_t p, logic [4:0] n);
			phase = p;
			bits_left = n;
			accum = '0;
		endfunction

		function logic [30:0] sign_extend(logic [30:0] v, logic [4:0] w);
			logic [30:0] m;
			if (w == 5'd0)
				return '0;
			m = (w == 5'd31) ? {31{1'b1}} : ((31'd1 << w) - 31'd1);
			v = v & m;
			if (v[w - 1])
				v = v | ~m;
			return v;
		endfunction

		function bit close_field(logic [30:0] v);
			logic [30:0]    s;
			bit             more;
			bit             done;
			matrix_result_t r;
			more = 1;
			done = 0;
			while (more) begin
				s = sign_extend(v, fwidth);
				more = 0;
				case (phase)
					bmrp_pkg::PH_SF: begin
						flags[0] = v[0];
						if (v[0])
							arm(bmrp_pkg::PH_SNB, bmrp_pkg::WIDTH_LEN);
						else
							arm(bmrp_pkg::PH_RF, bmrp_pkg::FLAG_LEN);
					end
					bmrp_pkg::PH_SNB: begin
						fwidth = v[4:0];
						phase = bmrp_pkg::PH_SX;
						more = 1;
					end
					bmrp_pkg::PH_SX: begin
						vals[0] = s;
						phase = bmrp_pkg::PH_SY;
						more = 1;
					end
					bmrp_pkg::PH_SY: begin
						vals[1] = s;
						arm(bmrp_pkg::PH_RF, bmrp_pkg::FLAG_LEN);
					end
					bmrp_pkg::PH_RF: begin
						flags[1] = v[0];
						if (v[0])
							arm(bmrp_pkg::PH_RNB, bmrp_pkg::WIDTH_LEN);
						else
							arm(bmrp_pkg::PH_TNB, bmrp_pkg::WIDTH_LEN);
					end
					bmrp_pkg::PH_RNB: begin
						fwidth = v[4:0];
						phase = bmrp_pkg::PH_KA;
						more = 1;
					end
					bmrp_pkg::PH_KA: begin
						vals[2] = s;
						phase = bmrp_pkg::PH_KB;
						more = 1;
					end
					bmrp_pkg::PH_KB: begin
						vals[3] = s;
						arm(bmrp_pkg::PH_TNB, bmrp_pkg::WIDTH_LEN);
					end
					bmrp_pkg::PH_TNB: begin
						fwidth = v[4:0];
						phase = bmrp_pkg::PH_TX;
						more = 1;
					end
					bmrp_pkg::PH_TX: begin
						vals[4] = s;
						phase = bmrp_pkg::PH_TY;
						more = 1;
					end
					default: begin
						r.status = 1'b0;
						r.has_scale = flags[0];
						r.scale_x = vals[0];
						r.scale_y = vals[1];
						r.has_rotate = flags[1];
						r.skew_a = vals[2];
						r.skew_b = vals[3];
						r.move_x = vals[4];
						r.move_y = s;
						r.record_bytes = nbytes;
						pending_records.push_back(r);
						done = 1;
					end
				endcase
				if (more) begin
					if (fwidth == 5'd0) begin
						v = '0;
					end else begin
						arm(phase, fwidth);
						more = 0;
					end
				end
			end
			return done;
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			matrix_result_t r;
			nbytes = nbytes + 5'd1;
			for (int i = 7; i >= 0; i--) begin
				accum = {accum[29:0], b[i]};
				bits_left = bits_left - 5'd1;
				if (bits_left == 5'd0 && close_field(accum)) begin
					restart();
					return;
				end
			end
			if (last) begin
				r.status = 1'b1;
				r.has_scale = 1'b0;
				r.scale_x = '0;
				r.scale_y = '0;
				r.has_rotate = 1'b0;
				r.skew_a = '0;
				r.skew_b = '0;
				r.move_x = '0;
				r.move_y = '0;
				r.record_bytes = nbytes;
				pending_records.push_back(r);
				restart();
			end
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_field(string name, logic [30:0] got, logic [30:0] want);
			if (got !== want)
				report($sformatf("record %0d %s got %0h want %0h", checked, name, got, want));
		endtask

		task check_result(matrix_result_t got);
			matrix_result_t want;
			if (pending_records.size() == 0) begin
				report("result with no record pending");
				return;
			end
			want = pending_records.pop_front();
			check_field("status", 31'(got.status), 31'(want.status));
			check_field("has_scale", 31'(got.has_scale), 31'(want.has_scale));
			check_field("scale_x", got.scale_x, want.scale_x);
			check_field("scale_y", got.scale_y, want.scale_y);
			check_field("has_rotate", 31'(got.has_rotate), 31'(want.has_rotate));
			check_field("skew_a", got.skew_a, want.skew_a);
			check_field("skew_b", got.skew_b, want.skew_b);
			check_field("move_x", got.move_x, want.move_x);
			check_field("move_y", got.move_y, want.move_y);
			check_field("record_bytes", 31'(got.record_bytes), 31'(want.record_bytes));
			if (want.status)
				truncated++;
			checked++;
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         in_byte;
	logic               end_of_data;
	logic               out_valid;
	logic               out_stall;
	logic               status;
	logic               has_scale;
	logic signed [30:0] scale_x;
	logic signed [30:0] scale_y;
	logic               has_rotate;
	logic signed [30:0] skew_a;
	logic signed [30:0] skew_b;
	logic signed [30:0] move_x;
	logic signed [30:0] move_y;
	logic [4:0]         record_bytes;

	record_scoreboard sb;
	matrix_result_t   seen;
	bit               stream_bits[$];
	logic [7:0]       octets[$];
	int               idle_pct;
	int               stall_pct;
	int               bytes_sent;

	bitpacked_matrix_record_parser_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.end_of_data(end_of_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.has_scale(has_scale),
		.scale_x(scale_x),
		.scale_y(scale_y),
		.has_rotate(has_rotate),
		.skew_a(skew_a),
		.skew_b(skew_b),
		.move_x(move_x),
		.move_y(move_y),
		.record_bytes(record_bytes)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("timeout with %0d records pending", sb.pending_records.size());
		$display("status: fail");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= arst_n && ($urandom_range(0, 99) < stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			seen.status = status;
			seen.has_scale = has_scale;
			seen.scale_x = scale_x;
			seen.scale_y = scale_y;
			seen.has_rotate = has_rotate;
			seen.skew_a = skew_a;
			seen.skew_b = skew_b;
			seen.move_x = move_x;
			seen.move_y = move_y;
			seen.record_bytes = record_bytes;
			sb.check_result(seen);
		end
	end

	task send_byte(logic [7:0] b, logic eod);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		end_of_data <= eod;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_byte(b, eod);
		bytes_sent++;
	endtask

	task push_field(int n, logic [30:0] v);
		for (int i = n - 1; i >= 0; i--)
			stream_bits.push_back(v[i]);
	endtask

	task build_record(bit hs, int ws, logic [30:0] sx, logic [30:0] sy,
			bit hr, int wr, logic [30:0] ka, logic [30:0] kb,
			int wt, logic [30:0] tx, logic [30:0] ty);
		logic [7:0] b;
		stream_bits.delete();
		octets.delete();
		push_field(1, 31'(hs));
		if (hs) begin
			push_field(5, 31'(ws));
			push_field(ws, sx);
			push_field(ws, sy);
		end
		push_field(1, 31'(hr));
		if (hr) begin
			push_field(5, 31'(wr));
			push_field(wr, ka);
			push_field(wr, kb);
		end
		push_field(5, 31'(wt));
		push_field(wt, tx);
		push_field(wt, ty);
		while (stream_bits.size() % 8 != 0)
			stream_bits.push_back(1'($urandom_range(0, 1)));
		while (stream_bits.size() != 0) begin
			for (int i = 7; i >= 0; i--)
				b[i] = stream_bits.pop_front();
			octets.push_back(b);
		end
	endtask

	task send_octets(int count, bit eod_at_end);
		for (int i = 0; i < count; i++)
			send_byte(octets[i], eod_at_end && (i == count - 1));
	endtask

	function int pick_width();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return 0;
		if (r < 24)
			return 31;
		return $urandom_range(1, 30);
	endfunction

	function logic [30:0] pick_value(int w);
		logic [30:0] m;
		if (w == 0)
			return '0;
		m = (w == 31) ? {31{1'b1}} : ((31'd1 << w) - 31'd1);
		case ($urandom_range(0, 7))
			0: return m;
			1: return m >> 1;
			2: return (m >> 1) + 31'd1;
			3: return '0;
			default: return 31'($urandom()) & m;
		endcase
	endfunction

	initial begin
		int total;
		int r;
		int ws;
		int wr;
		int wt;
		int cut;
		int waited;
		sb = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_byte <= '0;
		end_of_data <= 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		bytes_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'h00, 1'b0);
		build_record(1, 31, 31'h3FFFFFFF, 31'h40000000, 0, 0, '0, '0,
			31, 31'h7FFFFFFF, 31'h00000000);
		send_octets(octets.size(), 1);
		build_record(0, 0, '0, '0, 1, 1, 31'h1, 31'h0, 0, '0, '0);
		send_octets(octets.size(), 0);
		build_record(1, 0, '0, '0, 1, 0, '0, '0, 0, '0, '0);
		send_octets(octets.size(), 0);
		send_byte(8'hFF, 1'b1);

		total = 650;
		while (bytes_sent < total + 24) begin
			case ((bytes_sent - 24) * 4 / total)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 87; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 87; end
				default: begin idle_pct = 8; stall_pct = 8; end
			endcase
			r = $urandom_range(0, 99);
			if (r < 85) begin
				ws = pick_width();
				wr = pick_width();
				wt = pick_width();
				build_record($urandom_range(0, 1), ws, pick_value(ws), pick_value(ws),
					$urandom_range(0, 1), wr, pick_value(wr), pick_value(wr),
					wt, pick_value(wt), pick_value(wt));
				if (r < 8 && octets.size() > 1) begin
					cut = $urandom_range(1, octets.size() - 1);
					send_octets(cut, 1);
				end else begin
					send_octets(octets.size(), $urandom_range(0, 99) < 20);
				end
			end else begin
				repeat ($urandom_range(0, 4))
					send_byte(8'($urandom()), 1'b0);
				send_byte(8'($urandom()), 1'b1);
			end
		end

		in_valid <= 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		waited = 0;
		while (sb.pending_records.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (30) @(posedge clk);
		if (sb.pending_records.size() != 0)
			sb.report($sformatf("%0d records never produced", sb.pending_records.size()));

		$display("sent %0d stream bytes, checked %0d records (%0d truncated)",
			bytes_sent, sb.checked, sb.truncated);
		$display("idle phases: none, sender 87%%, receiver 87%%, both 8%%");
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
